>>> hdl/ort_pkg.sv
// Package for the outstanding request tracker: operation and slot state codes,
// the entry record, the slot update result and the configuration constants.
// No dependencies.
package ort_pkg;

    localparam int TABLE_SLOTS = 16;

    localparam int KIND_W   = 8;
    localparam int KEY_W    = 64;
    localparam int TIME_W   = 32;
    localparam int RETRY_W  = 4;
    localparam int SID_W    = 4;
    localparam int STATE_W  = 3;
    localparam int COUNT_W  = 5;
    localparam int TICKS_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEANUP = 2'd2;

    localparam logic [TICKS_W-1:0] TIMEOUT_RST = 16'd30;
    localparam logic [RETRY_W-1:0] RETRY_RST   = 4'd3;
    localparam logic [TICKS_W-1:0] CLEANUP_RST = 16'd300;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_ADD        = 3'd1,
        OP_COMPLETE   = 3'd2,
        OP_FAIL       = 3'd3,
        OP_STATUS     = 3'd4,
        OP_CACHED     = 3'd5,
        OP_CLEAR_EXP  = 3'd6,
        OP_CLEAR_ALL  = 3'd7
    } op_t;

    typedef enum logic [STATE_W-1:0] {
        SS_FREE      = 3'd0,
        SS_PENDING   = 3'd1,
        SS_COMPLETED = 3'd2,
        SS_FAILED    = 3'd3,
        SS_EXPIRED   = 3'd4
    } slot_state_t;

    typedef enum logic [1:0] {
        FSM_IDLE   = 2'd0,
        FSM_RUN    = 2'd1,
        FSM_FINISH = 2'd2
    } fsm_t;

    typedef struct packed {
        slot_state_t          status;
        logic [KIND_W-1:0]    kind;
        logic [KEY_W-1:0]     target;
        logic [TIME_W-1:0]    deadline;
        logic [RETRY_W-1:0]   retries;
        logic [RETRY_W-1:0]   retry_cap;
    } entry_t;

    typedef struct packed {
        logic        wr_en;
        logic        changed;
        logic        alloc;
        logic        ok;
        logic        hit;
        slot_state_t cur_status;
        slot_state_t new_status;
        entry_t      wr_entry;
    } upd_t;

endpackage

>>> hdl/ort_entry_ram.sv
// Entry memory of the tracker: one write port and one read port with
// registered read data. Generic; no package dependencies.
module ort_entry_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int WIDTH  = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/ort_slot_update.sv
// Read-modify-write logic for one slot of the tracker.
// Depends on ort_pkg for the operation codes, entry record and update result.
module ort_slot_update import ort_pkg::*; (
    input  op_t                 op,
    input  logic                slot_valid,
    input  entry_t              rd_entry,
    input  logic [TIME_W-1:0]   time_now,
    input  logic [TICKS_W-1:0]  timeout_ticks,
    input  logic [TICKS_W-1:0]  cleanup_ticks,
    input  logic [RETRY_W-1:0]  retry_limit,
    input  logic [KIND_W-1:0]   kind_code,
    input  logic [KEY_W-1:0]    target_key,
    output upd_t                upd
);

    slot_state_t         cur;
    slot_state_t         nxt_status;
    slot_state_t         tick_status;
    logic [TIME_W-1:0]   diff;
    logic [TIME_W-1:0]   new_deadline;
    logic [RETRY_W-1:0]  retries_inc;
    logic                force_wr;
    entry_t              nxt;

    always_comb begin
        cur          = slot_valid ? rd_entry.status : SS_FREE;
        diff         = time_now - rd_entry.deadline;
        new_deadline = time_now + TIME_W'(timeout_ticks);
        retries_inc  = rd_entry.retries + RETRY_W'(1);
        nxt          = rd_entry;
        nxt_status   = cur;
        tick_status  = cur;
        force_wr     = 1'b0;
        upd          = '0;

        unique case (op)
            OP_TICK: begin
                if (cur == SS_PENDING && !diff[TIME_W-1]) begin
                    tick_status = SS_EXPIRED;
                end
                if (tick_status == SS_EXPIRED && diff > TIME_W'(cleanup_ticks)) begin
                    tick_status = SS_FREE;
                end
                nxt_status = tick_status;
            end
            OP_ADD: begin
                if (cur == SS_FREE) begin
                    nxt_status    = SS_PENDING;
                    nxt.kind      = kind_code;
                    nxt.target    = target_key;
                    nxt.deadline  = new_deadline;
                    nxt.retries   = '0;
                    nxt.retry_cap = retry_limit;
                    upd.alloc     = 1'b1;
                    upd.ok        = 1'b1;
                end
            end
            OP_COMPLETE: begin
                if (cur == SS_PENDING) begin
                    nxt_status = SS_COMPLETED;
                    upd.ok     = 1'b1;
                end
            end
            OP_FAIL: begin
                if (cur == SS_PENDING) begin
                    nxt.retries = retries_inc;
                    force_wr    = 1'b1;
                    upd.ok      = 1'b1;
                    if (retries_inc < rd_entry.retry_cap) begin
                        nxt.deadline = new_deadline;
                    end else begin
                        nxt_status = SS_FAILED;
                    end
                end
            end
            OP_STATUS: begin
            end
            OP_CACHED: begin
                upd.hit = (cur == SS_PENDING || cur == SS_COMPLETED) &&
                          rd_entry.kind == kind_code && rd_entry.target == target_key;
            end
            OP_CLEAR_EXP: begin
                if (cur == SS_EXPIRED) begin
                    nxt_status = SS_FREE;
                end
            end
            OP_CLEAR_ALL: begin
            end
        endcase

        nxt.status     = nxt_status;
        upd.cur_status = cur;
        upd.new_status = nxt_status;
        upd.changed    = nxt_status != cur;
        upd.wr_en      = upd.changed || force_wr;
        upd.wr_entry   = nxt;
    end

endmodule

>>> hdl/outstanding_request_tracker_unit.sv
// Top level of the outstanding request tracker: sequencer, valid bits, counts,
// time and configuration registers. Depends on ort_pkg, ort_entry_ram and
// ort_slot_update.
//
//  Channel   Direction  Handshake              Transaction
//  s_*       in         s_valid / s_ready      one request
//  m_*       out        m_valid / m_ready      one result with the four counts
//  cfg_*     in         cfg_valid / cfg_ready  one register write
//
// Tick, add, cached query and clear expired sweep the entry memory one slot a
// cycle through its single read port, an add ending at the first free slot.
// Complete, fail and status visit only the named slot; clear all and
// out-of-range slots skip the sweep. Reset clears the valid bits at once, so
// no clearing pass runs. A new request is taken while a result waits on
// m_ready; its own result then waits in FSM_FINISH until the output is free.
module outstanding_request_tracker_unit import ort_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [2:0]             s_req_type,
    input  logic [SID_W-1:0]       s_slot_id,
    input  logic [KIND_W-1:0]      s_kind_code,
    input  logic [KEY_W-1:0]       s_target_key,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_ok,
    output logic                   m_table_full,
    output logic [SID_W-1:0]       m_new_slot,
    output logic [STATE_W-1:0]     m_entry_state,
    output logic                   m_cache_hit,
    output logic [COUNT_W-1:0]     m_pending_count,
    output logic [COUNT_W-1:0]     m_completed_count,
    output logic [COUNT_W-1:0]     m_failed_count,
    output logic [COUNT_W-1:0]     m_expired_count,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TABLE_SLOTS - 1);

    fsm_t                  state_reg, state_next;
    op_t                   op_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic [KEY_W-1:0]      key_reg;

    logic [SLOT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [SLOT_W-1:0]     last_idx_reg, last_idx_next;
    logic [SLOT_W-1:0]     proc_idx_reg;
    logic                  issue_reg, issue_next;
    logic                  proc_vld_reg, proc_vld_next;

    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]      cnt_reg [4];
    logic [CNT_W-1:0]      cnt_next [4];
    logic [TIME_W-1:0]     time_reg, time_next;

    logic [TICKS_W-1:0]    timeout_reg;
    logic [RETRY_W-1:0]    retry_reg;
    logic [TICKS_W-1:0]    cleanup_reg;

    logic                  ok_acc_reg, ok_acc_next;
    logic                  hit_acc_reg, hit_acc_next;
    logic                  alloc_acc_reg, alloc_acc_next;
    logic [SID_W-1:0]      slot_acc_reg, slot_acc_next;
    logic [STATE_W-1:0]    estate_acc_reg, estate_acc_next;

    logic                  m_valid_reg, m_valid_next;

    logic                  s_ready_int;
    logic                  issue_en;
    logic                  proc_en;
    logic                  load_out;
    logic                  in_acc;
    logic                  in_single;
    logic                  in_direct;
    logic                  run_done;
    logic [SLOT_W-1:0]     in_start;

    logic [$bits(entry_t)-1:0] rd_data;
    entry_t                rd_entry;
    upd_t                  upd;

    ort_entry_ram #(
        .DEPTH  (TABLE_SLOTS),
        .ADDR_W (SLOT_W),
        .WIDTH  ($bits(entry_t))
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (proc_en && upd.wr_en),
        .wr_addr (proc_idx_reg),
        .wr_data (upd.wr_entry),
        .rd_en   (issue_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    assign rd_entry = entry_t'(rd_data);

    ort_slot_update u_slot_update (
        .op            (op_reg),
        .slot_valid    (valid_reg[proc_idx_reg]),
        .rd_entry      (rd_entry),
        .time_now      (time_reg),
        .timeout_ticks (timeout_reg),
        .cleanup_ticks (cleanup_reg),
        .retry_limit   (retry_reg),
        .kind_code     (kind_reg),
        .target_key    (key_reg),
        .upd           (upd)
    );

    assign s_ready   = s_ready_int;
    assign m_valid   = m_valid_reg;
    assign cfg_ready = 1'b1;
    assign in_acc    = s_valid && s_ready_int;

    always_comb begin
        in_single = (op_t'(s_req_type) == OP_COMPLETE) || (op_t'(s_req_type) == OP_FAIL) ||
                    (op_t'(s_req_type) == OP_STATUS);
        in_direct = (op_t'(s_req_type) == OP_CLEAR_ALL) ||
                    (in_single && !(32'(s_slot_id) < TABLE_SLOTS));
        in_start  = in_single ? SLOT_W'(s_slot_id) : '0;
        run_done  = proc_vld_reg && (proc_idx_reg == last_idx_reg || upd.alloc);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    state_next = in_direct ? FSM_FINISH : FSM_RUN;
                end
            end
            FSM_RUN: begin
                if (run_done) begin
                    state_next = FSM_FINISH;
                end
            end
            FSM_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready_int = 1'b0;
        issue_en    = 1'b0;
        proc_en     = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            FSM_IDLE: begin
                s_ready_int = 1'b1;
            end
            FSM_RUN: begin
                issue_en = issue_reg;
                proc_en  = proc_vld_reg;
            end
            FSM_FINISH: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        rd_idx_next     = rd_idx_reg;
        last_idx_next   = last_idx_reg;
        issue_next      = issue_en && (rd_idx_reg != last_idx_reg) && !run_done;
        proc_vld_next   = issue_en && !run_done;
        valid_next      = valid_reg;
        time_next       = time_reg;
        ok_acc_next     = ok_acc_reg;
        hit_acc_next    = hit_acc_reg;
        alloc_acc_next  = alloc_acc_reg;
        slot_acc_next   = slot_acc_reg;
        estate_acc_next = estate_acc_reg;
        m_valid_next    = m_valid_reg;
        for (int k = 0; k < 4; k++) begin
            cnt_next[k] = cnt_reg[k];
        end

        if (issue_en) begin
            rd_idx_next = rd_idx_reg + SLOT_W'(1);
        end

        if (in_acc) begin
            rd_idx_next     = in_start;
            last_idx_next   = in_single ? in_start : LAST_IDX;
            issue_next      = !in_direct;
            ok_acc_next     = 1'b0;
            hit_acc_next    = 1'b0;
            alloc_acc_next  = 1'b0;
            slot_acc_next   = '0;
            estate_acc_next = '0;
            if (op_t'(s_req_type) == OP_TICK) begin
                time_next = time_reg + TIME_W'(1);
            end
            if (op_t'(s_req_type) == OP_CLEAR_ALL) begin
                valid_next = '0;
                for (int k = 0; k < 4; k++) begin
                    cnt_next[k] = '0;
                end
            end
        end

        if (proc_en) begin
            ok_acc_next  = ok_acc_reg || upd.ok;
            hit_acc_next = hit_acc_reg || upd.hit;
            if (upd.alloc) begin
                alloc_acc_next = 1'b1;
                slot_acc_next  = SID_W'(proc_idx_reg);
            end
            if (op_reg == OP_STATUS) begin
                estate_acc_next = upd.cur_status;
            end
            if (upd.changed) begin
                valid_next[proc_idx_reg] = upd.new_status != SS_FREE;
                for (int k = 0; k < 4; k++) begin
                    cnt_next[k] = cnt_reg[k]
                                + CNT_W'(upd.new_status == slot_state_t'(STATE_W'(k + 1)))
                                - CNT_W'(upd.cur_status == slot_state_t'(STATE_W'(k + 1)));
                end
            end
        end

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            issue_reg    <= 1'b0;
            proc_vld_reg <= 1'b0;
            valid_reg    <= '0;
            time_reg     <= '0;
            m_valid_reg  <= 1'b0;
            timeout_reg  <= TIMEOUT_RST;
            retry_reg    <= RETRY_RST;
            cleanup_reg  <= CLEANUP_RST;
            for (int k = 0; k < 4; k++) begin
                cnt_reg[k] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            issue_reg    <= issue_next;
            proc_vld_reg <= proc_vld_next;
            valid_reg    <= valid_next;
            time_reg     <= time_next;
            m_valid_reg  <= m_valid_next;
            for (int k = 0; k < 4; k++) begin
                cnt_reg[k] <= cnt_next[k];
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_TIMEOUT: timeout_reg <= cfg_wdata;
                    CFG_RETRY:   retry_reg   <= RETRY_W'(cfg_wdata);
                    CFG_CLEANUP: cleanup_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        last_idx_reg   <= last_idx_next;
        proc_idx_reg   <= rd_idx_reg;
        ok_acc_reg     <= ok_acc_next;
        hit_acc_reg    <= hit_acc_next;
        alloc_acc_reg  <= alloc_acc_next;
        slot_acc_reg   <= slot_acc_next;
        estate_acc_reg <= estate_acc_next;
        if (in_acc) begin
            op_reg      <= op_t'(s_req_type);
            kind_reg    <= s_kind_code;
            key_reg     <= s_target_key;
        end
        if (load_out) begin
            m_ok              <= ok_acc_reg;
            m_table_full      <= (op_reg == OP_ADD) && !alloc_acc_reg;
            m_new_slot        <= slot_acc_reg;
            m_entry_state     <= estate_acc_reg;
            m_cache_hit       <= hit_acc_reg;
            m_pending_count   <= COUNT_W'(cnt_reg[0]);
            m_completed_count <= COUNT_W'(cnt_reg[1]);
            m_failed_count    <= COUNT_W'(cnt_reg[2]);
            m_expired_count   <= COUNT_W'(cnt_reg[3]);
        end
    end

    // The four state counts together never exceed the number of slots.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg[0]) + 32'(cnt_reg[1]) + 32'(cnt_reg[2]) + 32'(cnt_reg[3])
            <= TABLE_SLOTS)
        else $error("state counts exceed the table size");

    // No memory read is in flight while the block waits for a new request.
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == FSM_IDLE |-> !issue_reg && !proc_vld_reg)
        else $error("memory sweep still active in idle");

    // A clear-all transaction leaves every count at zero.
    a_clear_all: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && op_t'(s_req_type) == OP_CLEAR_ALL |=>
            cnt_reg[0] == '0 && cnt_reg[1] == '0 && cnt_reg[2] == '0 && cnt_reg[3] == '0)
        else $error("counts not cleared by clear all");

    // A refused add never reports success.
    a_full_not_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_ok && m_table_full))
        else $error("result reports both success and a full table");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for outstanding_request_tracker_unit: a directed table and random
// traffic under several register settings, checked against a request table predictor.
// Depends on ort_pkg and the RTL of the tracker.
module tb import ort_pkg::*;;

    localparam int SLOTS           = TABLE_SLOTS;
    localparam int N_DIRECTED      = 30;
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 325;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int TAIL_CYCLES     = 24;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [KEY_W-1:0] KEY_ZERO = '0;
    localparam logic [KEY_W-1:0] KEY_ONES = '1;
    localparam logic [KEY_W-1:0] KEY_MIX  = 64'h0123_4567_89ab_cdef;

    typedef struct packed {
        logic               ok;
        logic               table_full;
        logic [SID_W-1:0]   new_slot;
        logic [STATE_W-1:0] entry_state;
        logic               cache_hit;
        logic [COUNT_W-1:0] pending;
        logic [COUNT_W-1:0] completed;
        logic [COUNT_W-1:0] failed;
        logic [COUNT_W-1:0] expired;
    } result_t;

    typedef struct {
        bit                    cfg_row;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        op_t                   op;
        logic [SID_W-1:0]      sid;
        logic [KIND_W-1:0]     kind;
        logic [KEY_W-1:0]      key;
        bit                    typed;
        result_t               res;
    } stim_row_t;

    localparam result_t ALL_ZERO  = '0;
    localparam result_t ONE_ADDED = '{1'b1, 1'b0, 4'd0, 3'd0, 1'b0, 5'd1, 5'd0, 5'd0, 5'd0};

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [2:0]             s_req_type = '0;
    logic [SID_W-1:0]       s_slot_id = '0;
    logic [KIND_W-1:0]      s_kind_code = '0;
    logic [KEY_W-1:0]       s_target_key = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_ok;
    logic                   m_table_full;
    logic [SID_W-1:0]       m_new_slot;
    logic [STATE_W-1:0]     m_entry_state;
    logic                   m_cache_hit;
    logic [COUNT_W-1:0]     m_pending_count;
    logic [COUNT_W-1:0]     m_completed_count;
    logic [COUNT_W-1:0]     m_failed_count;
    logic [COUNT_W-1:0]     m_expired_count;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    outstanding_request_tracker_unit dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req_type(s_req_type),
        .s_slot_id(s_slot_id),
        .s_kind_code(s_kind_code),
        .s_target_key(s_target_key),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_ok(m_ok),
        .m_table_full(m_table_full),
        .m_new_slot(m_new_slot),
        .m_entry_state(m_entry_state),
        .m_cache_hit(m_cache_hit),
        .m_pending_count(m_pending_count),
        .m_completed_count(m_completed_count),
        .m_failed_count(m_failed_count),
        .m_expired_count(m_expired_count),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // Request table as the testbench sees it.
    slot_state_t         slot_st    [SLOTS];
    logic [KIND_W-1:0]   slot_kd    [SLOTS];
    logic [KEY_W-1:0]    slot_key   [SLOTS];
    logic [TIME_W-1:0]   slot_due   [SLOTS];
    logic [RETRY_W-1:0]  slot_tries [SLOTS];
    logic [RETRY_W-1:0]  slot_cap   [SLOTS];
    logic [TIME_W-1:0]   now_ticks;
    logic [TICKS_W-1:0]  cur_timeout;
    logic [RETRY_W-1:0]  cur_retry;
    logic [TICKS_W-1:0]  cur_cleanup;

    result_t     due_results [$];
    logic [KIND_W-1:0] pool_kind [4];
    logic [KEY_W-1:0]  pool_key  [4];
    bit          idle_on = 1'b0;
    int          fail_count = 0;
    int          reports = 0;
    int unsigned cycle_count = 0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_STATUS,    4'd0,  8'h00, KEY_ZERO, 1'b1, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_TICK,      4'd0,  8'h00, KEY_ZERO, 1'b1, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_COMPLETE,  4'd5,  8'h00, KEY_ZERO, 1'b1, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_FAIL,      4'd15, 8'h00, KEY_ZERO, 1'b1, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_CACHED,    4'd0,  8'h00, KEY_ZERO, 1'b1, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_ADD,       4'd0,  8'hff, KEY_ONES, 1'b1, ONE_ADDED},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_ADD,       4'd0,  8'h00, KEY_ZERO, 1'b0, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_CACHED,    4'd0,  8'hff, KEY_ONES, 1'b0, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_CACHED,    4'd0,  8'hff, KEY_ZERO, 1'b0, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_STATUS,    4'd0,  8'h00, KEY_ZERO, 1'b0, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_COMPLETE,  4'd0,  8'h00, KEY_ZERO, 1'b0, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_COMPLETE,  4'd0,  8'h00, KEY_ZERO, 1'b0, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_CACHED,    4'd0,  8'hff, KEY_ONES, 1'b0, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_FAIL,      4'd1,  8'h00, KEY_ZERO, 1'b0, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_FAIL,      4'd1,  8'h00, KEY_ZERO, 1'b0, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_FAIL,      4'd1,  8'h00, KEY_ZERO, 1'b0, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_STATUS,    4'd1,  8'h00, KEY_ZERO, 1'b0, ALL_ZERO},
        '{1'b1, CFG_TIMEOUT, 16'h0000, OP_TICK,      4'd0,  8'h00, KEY_ZERO, 1'b0, ALL_ZERO},
        '{1'b1, CFG_RETRY,   16'h0000, OP_TICK,      4'd0,  8'h00, KEY_ZERO, 1'b0, ALL_ZERO},
        '{1'b1, CFG_CLEANUP, 16'h0000, OP_TICK,      4'd0,  8'h00, KEY_ZERO, 1'b0, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_ADD,       4'd0,  8'h5a, KEY_MIX,  1'b0, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_FAIL,      4'd2,  8'h00, KEY_ZERO, 1'b0, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_ADD,       4'd0,  8'ha5, KEY_MIX,  1'b0, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_TICK,      4'd0,  8'h00, KEY_ZERO, 1'b0, ALL_ZERO},
        '{1'b1, CFG_CLEANUP, 16'hffff, OP_TICK,      4'd0,  8'h00, KEY_ZERO, 1'b0, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_ADD,       4'd0,  8'h3c, KEY_MIX,  1'b0, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_TICK,      4'd0,  8'h00, KEY_ZERO, 1'b0, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_STATUS,    4'd3,  8'h00, KEY_ZERO, 1'b0, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_CLEAR_EXP, 4'd0,  8'h00, KEY_ZERO, 1'b0, ALL_ZERO},
        '{1'b0, CFG_TIMEOUT, 16'h0000, OP_CLEAR_ALL, 4'd0,  8'h00, KEY_ZERO, 1'b1, ALL_ZERO}
    };

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic result_t track_request(input op_t op, input logic [SID_W-1:0] sid,
                                              input logic [KIND_W-1:0] kind,
                                              input logic [KEY_W-1:0] key);
        result_t r;
        logic [TIME_W-1:0] age;
        logic [RETRY_W-1:0] tries;
        int i;
        r = '0;
        case (op)
            OP_TICK: begin
                now_ticks = now_ticks + 1'b1;
                for (i = 0; i < SLOTS; i++) begin
                    age = now_ticks - slot_due[i];
                    if (slot_st[i] == SS_PENDING && !age[TIME_W-1]) slot_st[i] = SS_EXPIRED;
                end
                for (i = 0; i < SLOTS; i++) begin
                    age = now_ticks - slot_due[i];
                    if (slot_st[i] == SS_EXPIRED && age > TIME_W'(cur_cleanup)) begin
                        slot_st[i] = SS_FREE;
                    end
                end
            end
            OP_ADD: begin
                r.table_full = 1'b1;
                for (i = 0; i < SLOTS && r.table_full; i++) begin
                    if (slot_st[i] == SS_FREE) begin
                        slot_st[i]    = SS_PENDING;
                        slot_kd[i]    = kind;
                        slot_key[i]   = key;
                        slot_due[i]   = now_ticks + TIME_W'(cur_timeout);
                        slot_tries[i] = '0;
                        slot_cap[i]   = cur_retry;
                        r.ok          = 1'b1;
                        r.table_full  = 1'b0;
                        r.new_slot    = SID_W'(i);
                    end
                end
            end
            OP_COMPLETE: begin
                if (slot_st[sid] == SS_PENDING) begin
                    slot_st[sid] = SS_COMPLETED;
                    r.ok = 1'b1;
                end
            end
            OP_FAIL: begin
                if (slot_st[sid] == SS_PENDING) begin
                    tries = slot_tries[sid] + 1'b1;
                    slot_tries[sid] = tries;
                    if (tries < slot_cap[sid]) begin
                        slot_due[sid] = now_ticks + TIME_W'(cur_timeout);
                    end else begin
                        slot_st[sid] = SS_FAILED;
                    end
                    r.ok = 1'b1;
                end
            end
            OP_STATUS: r.entry_state = slot_st[sid];
            OP_CACHED: begin
                for (i = 0; i < SLOTS; i++) begin
                    if ((slot_st[i] == SS_PENDING || slot_st[i] == SS_COMPLETED) &&
                        slot_kd[i] == kind && slot_key[i] == key) r.cache_hit = 1'b1;
                end
            end
            OP_CLEAR_EXP: begin
                for (i = 0; i < SLOTS; i++) begin
                    if (slot_st[i] == SS_EXPIRED) slot_st[i] = SS_FREE;
                end
            end
            default: begin
                for (i = 0; i < SLOTS; i++) slot_st[i] = SS_FREE;
            end
        endcase
        for (i = 0; i < SLOTS; i++) begin
            case (slot_st[i])
                SS_PENDING:   r.pending   = r.pending + 1'b1;
                SS_COMPLETED: r.completed = r.completed + 1'b1;
                SS_FAILED:    r.failed    = r.failed + 1'b1;
                SS_EXPIRED:   r.expired   = r.expired + 1'b1;
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic send_req(input op_t op, input logic [SID_W-1:0] sid,
                            input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                            input bit typed, input result_t typed_res);
        result_t predicted;
        while (idle_on && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= op;
        s_slot_id    <= sid;
        s_kind_code  <= kind;
        s_target_key <= key;
        do @(posedge aclk); while (!s_ready);
        predicted = track_request(op, sid, kind, key);
        if (typed) predicted = typed_res;
        due_results = {due_results, predicted};
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_TIMEOUT: cur_timeout = data;
            CFG_RETRY:   cur_retry   = data[RETRY_W-1:0];
            CFG_CLEANUP: cur_cleanup = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly well-formed traffic: completes and fails aim at live requests, and
    // adds and lookups reuse a small pool of kinds and targets so that hits occur.
    task automatic random_request();
        op_t op;
        int dice;
        int sel;
        int live [$];
        logic [SID_W-1:0] sid;
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0] key;
        dice = $urandom_range(99);
        sid  = SID_W'($urandom_range(SLOTS - 1));
        kind = KIND_W'($urandom_range(255));
        key  = {$urandom, $urandom};
        sel  = $urandom_range(3);
        if (dice < 25) begin
            op = OP_TICK;
        end else if (dice < 45) begin
            op = OP_ADD;
            if ($urandom_range(1) == 1) begin
                kind = pool_kind[sel];
                key  = pool_key[sel];
            end
        end else if (dice < 70) begin
            op = (dice < 58) ? OP_COMPLETE : OP_FAIL;
            for (int i = 0; i < SLOTS; i++) if (slot_st[i] == SS_PENDING) live = {live, i};
            if (live.size() != 0 && $urandom_range(99) < 80) begin
                sid = SID_W'(live[$urandom_range(live.size() - 1)]);
            end
        end else if (dice < 80) begin
            op = OP_STATUS;
        end else if (dice < 92) begin
            op = OP_CACHED;
            if ($urandom_range(99) < 60) begin
                sel  = $urandom_range(SLOTS - 1);
                kind = slot_kd[sel];
                key  = slot_key[sel];
            end else if ($urandom_range(1) == 1) begin
                kind = pool_kind[sel];
                key  = pool_key[sel];
            end
        end else if (dice < 97) begin
            op = OP_CLEAR_EXP;
        end else begin
            op = OP_CLEAR_ALL;
        end
        send_req(op, sid, kind, key, 1'b0, ALL_ZERO);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            if (reports < REPORT_LIMIT) begin
                reports++;
                $display("mismatch in %s: expected %0d, got %0d at cycle %0d",
                         name, want, got, cycle_count);
            end
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                fail_count++;
                if (reports < REPORT_LIMIT) begin
                    reports++;
                    $display("result transaction with no request waiting at cycle %0d",
                             cycle_count);
                end
            end else begin
                want = due_results.pop_front();
                check_field("ok", want.ok, m_ok);
                check_field("table_full", want.table_full, m_table_full);
                check_field("new_slot", want.new_slot, m_new_slot);
                check_field("entry_state", want.entry_state, m_entry_state);
                check_field("cache_hit", want.cache_hit, m_cache_hit);
                check_field("pending_count", want.pending, m_pending_count);
                check_field("completed_count", want.completed, m_completed_count);
                check_field("failed_count", want.failed, m_failed_count);
                check_field("expired_count", want.expired, m_expired_count);
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= !idle_on || ($urandom_range(99) >= 26);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [TICKS_W-1:0] t_val;
        logic [TICKS_W-1:0] c_val;
        logic [RETRY_W-1:0] r_val;
        for (int i = 0; i < SLOTS; i++) begin
            slot_st[i]    = SS_FREE;
            slot_kd[i]    = '0;
            slot_key[i]   = '0;
            slot_due[i]   = '0;
            slot_tries[i] = '0;
            slot_cap[i]   = '0;
        end
        for (int i = 0; i < 4; i++) begin
            pool_kind[i] = KIND_W'($urandom_range(255));
            pool_key[i]  = {$urandom, $urandom};
        end
        now_ticks   = '0;
        cur_timeout = TIMEOUT_RST;
        cur_retry   = RETRY_RST;
        cur_cleanup = CLEANUP_RST;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_on = 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            if (directed_rows[r].cfg_row) begin
                wait_drained();
                write_register(directed_rows[r].reg_idx, directed_rows[r].reg_data);
            end else begin
                send_req(directed_rows[r].op, directed_rows[r].sid, directed_rows[r].kind,
                         directed_rows[r].key, directed_rows[r].typed, directed_rows[r].res);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin t_val = 16'd1;     r_val = 4'd0;  c_val = 16'd0;     end
                1: begin t_val = 16'hffff;  r_val = 4'hf;  c_val = 16'hffff;  end
                2: begin t_val = 16'd5;     r_val = 4'd2;  c_val = 16'd12;    end
                3: begin t_val = 16'd0;     r_val = 4'd1;  c_val = 16'd3;     end
                4: begin
                    t_val = TICKS_W'($urandom_range(1, 40));
                    r_val = RETRY_W'($urandom_range(0, 15));
                    c_val = TICKS_W'($urandom_range(0, 80));
                end
                default: begin t_val = TIMEOUT_RST; r_val = RETRY_RST; c_val = CLEANUP_RST; end
            endcase
            write_register(CFG_TIMEOUT, t_val);
            write_register(CFG_RETRY, CFG_DATA_W'(r_val));
            write_register(CFG_CLEANUP, c_val);
            if (p == 4) write_register(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 65535)));
            idle_on = (p != 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                random_request();
                if ($urandom_range(99) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
